@@ rtl/sqp_pkg.sv @@
// Package for the SIP q-value parser: recognizer state codes, error and
// status codes, and small character and weight helpers. No dependencies.
`default_nettype none

package sqp_pkg;

    // Recognizer states.
    localparam logic [2:0] ST_BLANK  = 3'd0;  // skipping leading blanks
    localparam logic [2:0] ST_ZERO   = 3'd1;  // one or more zeros seen
    localparam logic [2:0] ST_ONE    = 3'd2;  // integer part is one
    localparam logic [2:0] ST_ZPT    = 3'd3;  // "0." or bare point seen
    localparam logic [2:0] ST_ONEPT  = 3'd4;  // "1." seen
    localparam logic [2:0] ST_ONEPT0 = 3'd5;  // "1.0" and further zeros
    localparam logic [2:0] ST_FRAC   = 3'd6;  // inside the decimals

    // Latched error codes.
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_CHAR = 2'd1;
    localparam logic [1:0] ERR_BIG  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_CHAR  = 2'd1;
    localparam logic [1:0] STAT_BIG   = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [6:0]  WEIGHT_RESET = 7'd100;
    localparam logic [2:0]  COUNT_RESET  = 3'd1;
    localparam logic [2:0]  COUNT_LIMIT  = 3'd3;
    localparam logic [10:0] Q_ONE        = 11'd1000;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Next place weight: the weight only ever holds 100, 10, 1 or 0.
    function automatic logic [6:0] weight_down(input logic [6:0] w);
        case (w)
            7'd100:  weight_down = 7'd10;
            7'd10:   weight_down = 7'd1;
            default: weight_down = 7'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ rtl/sip_qvalue_parser.sv @@
// Top level of the SIP q-value parser: a character-serial recognizer with a
// registered result stage. Depends on sqp_pkg.
`default_nettype none

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: ch[7:0]; tlast: last character of the string
// m_axis    out        tdata: q_value[9:0], zero pad[15:10]; tuser: status[1:0]
//
// One character is taken per cycle; its recognizer step completes in the cycle
// it is accepted, and a string's result is in the output register in the cycle
// after its last character. The input is stalled only while a result waits in
// the output register and the sink is not ready. Reset (synchronous, active
// low) returns the recognizer to its start state and empties the output.

module sip_qvalue_parser
    import sqp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // ch[7:0]
    input  wire logic        i_s_axis_tlast,   // last
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // q_value[9:0], zeros[15:10]
    output logic [1:0]       o_m_axis_tuser    // status[1:0]
);

    // Recognizer state.
    logic [2:0]  r_state, n_state;
    logic [10:0] r_acc,   n_acc;
    logic [6:0]  r_weight, n_weight;
    logic [2:0]  r_count, n_count;
    logic [1:0]  r_err,   n_err;

    // Result register.
    logic        r_out_valid;
    logic [9:0]  r_out_q;
    logic [1:0]  r_out_stat;

    logic        in_acc;
    logic [7:0]  ch;
    logic [3:0]  dig;
    logic [10:0] prod;
    logic [1:0]  digit_err;
    logic [9:0]  res_q;
    logic [1:0]  res_stat;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign ch              = i_s_axis_tdata;
    assign dig             = ch[3:0];
    // A digit that would push the value past one is "too big"; anything
    // else that does not fit the grammar is an invalid character.
    assign digit_err       = is_digit(ch) ? ERR_BIG : ERR_CHAR;
    assign prod            = 11'(dig * r_weight);

    // One recognizer step. Once an error is latched, characters are ignored.
    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_weight = r_weight;
        n_count  = r_count;
        n_err    = r_err;
        if (r_err == ERR_NONE) begin
            unique case (r_state) inside
                ST_BLANK: begin
                    if (ch == CH_SPACE || ch == CH_TAB) begin
                        n_state = ST_BLANK;
                    end else if (ch == CH_ZERO) begin
                        n_acc   = '0;
                        n_state = ST_ZERO;
                    end else if (ch == CH_ONE) begin
                        n_acc   = Q_ONE;
                        n_state = ST_ONE;
                    end else if (ch == CH_POINT) begin
                        n_acc   = '0;
                        n_state = ST_ZPT;
                    end else begin
                        n_err = ERR_CHAR;
                    end
                end
                ST_ZERO: begin
                    if (ch == CH_ZERO) begin
                        n_state = ST_ZERO;
                    end else if (ch == CH_POINT) begin
                        n_state = ST_ZPT;
                    end else if (ch == CH_ONE) begin
                        // Leading zeros before a one still give the value one.
                        n_acc   = Q_ONE;
                        n_state = ST_ONE;
                    end else begin
                        n_err = digit_err;
                    end
                end
                ST_ONE: begin
                    if (ch == CH_POINT) begin
                        n_state = ST_ONEPT;
                    end else begin
                        n_err = digit_err;
                    end
                end
                ST_ZPT: begin
                    if (is_digit(ch)) begin
                        n_acc    = prod;
                        n_weight = weight_down(r_weight);
                        n_state  = ST_FRAC;
                    end else begin
                        n_err = ERR_CHAR;
                    end
                end
                ST_ONEPT, ST_ONEPT0: begin
                    if (ch == CH_ZERO) begin
                        n_state = ST_ONEPT0;
                    end else begin
                        n_err = digit_err;
                    end
                end
                ST_FRAC: begin
                    if (is_digit(ch)) begin
                        // Decimals past the third are checked but add nothing.
                        if (r_count <= COUNT_LIMIT) begin
                            n_acc    = r_acc + prod;
                            n_weight = weight_down(r_weight);
                            n_count  = r_count + 3'd1;
                        end
                    end else begin
                        n_err = ERR_CHAR;
                    end
                end
                default: begin
                    n_state = ST_BLANK;
                end
            endcase
        end
    end

    // Result as seen after the last character's step.
    always_comb begin
        if (n_err != ERR_NONE) begin
            res_q    = '0;
            res_stat = n_err;
        end else if (n_state == ST_BLANK) begin
            res_q    = '0;
            res_stat = STAT_EMPTY;
        end else begin
            res_q    = n_acc[9:0];
            res_stat = STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_BLANK;
            r_acc    <= '0;
            r_weight <= WEIGHT_RESET;
            r_count  <= COUNT_RESET;
            r_err    <= ERR_NONE;
        end else if (in_acc) begin
            if (i_s_axis_tlast) begin
                r_state  <= ST_BLANK;
                r_acc    <= '0;
                r_weight <= WEIGHT_RESET;
                r_count  <= COUNT_RESET;
                r_err    <= ERR_NONE;
            end else begin
                r_state  <= n_state;
                r_acc    <= n_acc;
                r_weight <= n_weight;
                r_count  <= n_count;
                r_err    <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_axis_tlast) begin
            r_out_q    <= res_q;
            r_out_stat <= res_stat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_q};
    assign o_m_axis_tuser  = r_out_stat;

    // A string's end always leaves the recognizer clean for the next one.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tlast) |=> (r_state == ST_BLANK && r_err == ERR_NONE
            && r_acc == 11'd0 && r_weight == WEIGHT_RESET))
        else $error("recognizer not back at start after last character");

    // A latched error holds until the string ends.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE && !(in_acc && i_s_axis_tlast)) |=> $stable(r_err))
        else $error("latched error changed inside a string");

    // Any non-ok status reports a zero value, and ok never exceeds one.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_stat == STAT_OK && r_out_q <= Q_ONE[9:0])
            || (r_out_stat != STAT_OK && r_out_q == 10'd0)))
        else $error("result value inconsistent with status");

    // The weight only ever steps through 100, 10, 1, 0.
    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_weight == 7'd100 || r_weight == 7'd10 || r_weight == 7'd1
            || r_weight == 7'd0))
        else $error("place weight off its sequence");

endmodule

`default_nettype wire
